@@ hdl/mbe_pkg.sv @@
// shared types, constants and widths for the escape-time pixel engine
`default_nettype none

package mbe_pkg;

   // field and register widths
   localparam int MBE_COORD_WIDTH = 12;
   localparam int MBE_COUNT_WIDTH = 17;
   localparam int MBE_ORIGIN_WIDTH = 32;
   localparam int MBE_STEP_WIDTH = 31;
   localparam int MBE_CSR_DATA_WIDTH = 32;
   localparam int MBE_CSR_INDEX_WIDTH = 3;

   // default parameter values
   localparam int MBE_FRAC_BITS = 28;
   localparam int MBE_INDEX_WIDTH = 12;

   // datapath widths: point c, next z candidate, z, full products
   localparam int MBE_C_WIDTH = 46;
   localparam int MBE_NXT_WIDTH = 50;
   localparam int MBE_Z_WIDTH = 32;
   localparam int MBE_PROD_WIDTH = 64;

   // register reset values
   localparam logic [MBE_ORIGIN_WIDTH-1:0] MBE_X_ORIGIN_RST = 32'hE000_0000;
   localparam logic [MBE_STEP_WIDTH-1:0] MBE_X_STEP_RST = 31'd262144;
   localparam logic [MBE_ORIGIN_WIDTH-1:0] MBE_Y_ORIGIN_RST = 32'hF000_0000;
   localparam logic [MBE_STEP_WIDTH-1:0] MBE_Y_STEP_RST = 31'd262144;
   localparam logic [MBE_COUNT_WIDTH-1:0] MBE_LIMIT_RST = 17'd100000;

   // register indexes
   typedef enum logic [MBE_CSR_INDEX_WIDTH-1:0] {
      CSR_X_ORIGIN = 3'd0,
      CSR_X_STEP = 3'd1,
      CSR_Y_ORIGIN = 3'd2,
      CSR_Y_STEP = 3'd3,
      CSR_ITER_LIMIT = 3'd4
   } csr_index_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_CHECK,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic setup;
      logic mul;
      logic step;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic len_escape;
      logic limit_hit;
      logic overflow;
   } sts_type;

endpackage

`default_nettype wire

@@ hdl/mbe_if.sv @@
// valid/ready channel interfaces: pixel request, pixel result, register write
`default_nettype none

interface mbe_req_if import mbe_pkg::*; ();
   logic valid;
   logic ready;
   logic [MBE_COORD_WIDTH-1:0] col;
   logic [MBE_COORD_WIDTH-1:0] row;

   modport source (output valid, output col, output row, input ready);
   modport sink (input valid, input col, input row, output ready);
endinterface

interface mbe_rsp_if import mbe_pkg::*; ();
   logic valid;
   logic ready;
   logic [MBE_COORD_WIDTH-1:0] out_col;
   logic [MBE_COORD_WIDTH-1:0] out_row;
   logic [MBE_COUNT_WIDTH-1:0] escape_count;

   modport source (output valid, output out_col, output out_row, output escape_count,
                   input ready);
   modport sink (input valid, input out_col, input out_row, input escape_count,
                 output ready);
endinterface

interface mbe_csr_if import mbe_pkg::*; ();
   logic valid;
   logic ready;
   logic [MBE_CSR_INDEX_WIDTH-1:0] index;
   logic [MBE_CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/mandelbrot_escape_time.sv @@
// Mandelbrot escape-time pixel engine, top level
//
// req_chan carries one pixel position (col, row) per beat. The block maps it
// to c = (x_origin + col*x_step, y_origin + row*y_step) and iterates
// z = z*z + c from zero until |z|^2 reaches 4, a part of z leaves the signed
// 32-bit range, or iteration_limit iterations are done.
// rsp_chan returns one beat per pixel: out_col, out_row and escape_count.
// csr_chan writes registers by index (x_origin, x_step, y_origin, y_step,
// iteration_limit); it is always ready; the user must write it only while idle, as the block does not enforce this.
// Each iteration registers the products of the three 32x32 multipliers, then
// does the next-z adds and the escape compare.
// One pixel is in work at a time; the result register lets the next request
// be taken while a result beat waits. A stalled receiver holds the result,
// and a finished pixel then waits until the result register frees up.
// Reset clears the sequencer and the result valid, and loads the register
// defaults.
`default_nettype none

module mandelbrot_escape_time import mbe_pkg::*; #(
   parameter int FRAC_BITS = MBE_FRAC_BITS,
   parameter int INDEX_WIDTH = MBE_INDEX_WIDTH
) (
   input wire logic clock,
   input wire logic reset,
   mbe_req_if.sink  req_chan,
   mbe_rsp_if.source rsp_chan,
   mbe_csr_if.sink  csr_chan
);

   cmd_type cmd;
   sts_type sts;

   // register port takes every beat
   assign csr_chan.ready = 1'b1;

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mbe_dpath #(
      .FRAC_BITS   (FRAC_BITS),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_col          (req_chan.col),
      .req_row          (req_chan.row),
      .csr_write        (csr_chan.valid),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_out_col      (rsp_chan.out_col),
      .rsp_out_row      (rsp_chan.out_row),
      .rsp_escape_count (rsp_chan.escape_count)
   );

endmodule

`default_nettype wire

@@ hdl/mbe_ctrl.sv @@
// iteration sequencer and result handshake for the escape-time engine
`default_nettype none

module mbe_ctrl import mbe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.len_escape || sts.limit_hit || sts.overflow) state_in = ST_FINISH;
            else state_in = ST_MUL;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_CHECK: begin
            cmd.step = !sts.len_escape && !sts.limit_hit;
         end
         ST_FINISH: begin
            cmd.emit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // result beat pending flag
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/mbe_dpath.sv @@
// registers, point mapping, z iteration arithmetic and result register
`default_nettype none

module mbe_dpath import mbe_pkg::*; #(
   parameter int FRAC_BITS = MBE_FRAC_BITS,
   parameter int INDEX_WIDTH = MBE_INDEX_WIDTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [MBE_COORD_WIDTH-1:0]     req_col,
   input  wire logic [MBE_COORD_WIDTH-1:0]     req_row,
   input  wire logic                           csr_write,
   input  wire logic [MBE_CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [MBE_CSR_DATA_WIDTH-1:0]  csr_data,
   input  wire cmd_type                        cmd,
   output sts_type                             sts,
   output logic [MBE_COORD_WIDTH-1:0]          rsp_out_col,
   output logic [MBE_COORD_WIDTH-1:0]          rsp_out_row,
   output logic [MBE_COUNT_WIDTH-1:0]          rsp_escape_count
);

   localparam logic [MBE_COORD_WIDTH-1:0] IDX_MASK = (INDEX_WIDTH >= MBE_COORD_WIDTH) ?
      {MBE_COORD_WIDTH{1'b1}} : MBE_COORD_WIDTH'((1 << INDEX_WIDTH) - 1);
   localparam logic [MBE_PROD_WIDTH-1:0] FOUR = MBE_PROD_WIDTH'(4) << FRAC_BITS;
   localparam int PROD_C_WIDTH = MBE_COORD_WIDTH + MBE_STEP_WIDTH;

   // configuration registers
   logic signed [MBE_ORIGIN_WIDTH-1:0] x_origin_ff, y_origin_ff;
   logic [MBE_STEP_WIDTH-1:0] x_step_ff, y_step_ff;
   logic [MBE_COUNT_WIDTH-1:0] limit_ff;

   // pixel and iteration state
   logic [MBE_COORD_WIDTH-1:0] col_ff, row_ff;
   logic signed [MBE_C_WIDTH-1:0] c_re_ff, c_im_ff, c_re_in, c_im_in;
   logic signed [MBE_Z_WIDTH-1:0] x_ff, y_ff;
   logic [MBE_COUNT_WIDTH-1:0] count_ff;
   logic signed [MBE_PROD_WIDTH-1:0] xx_ff, yy_ff, xy_ff, xx_in, yy_in, xy_in;
   logic [PROD_C_WIDTH-1:0] col_prod, row_prod;
   logic signed [MBE_NXT_WIDTH-1:0] nx, ny;
   logic [MBE_PROD_WIDTH-1:0] mag_sum;
   logic nx_fits, ny_fits;

   // results
   logic [MBE_COORD_WIDTH-1:0] out_col_ff, out_row_ff;
   logic [MBE_COUNT_WIDTH-1:0] out_count_ff;

   // register writes, out-of-list indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= MBE_X_ORIGIN_RST;
         x_step_ff <= MBE_X_STEP_RST;
         y_origin_ff <= MBE_Y_ORIGIN_RST;
         y_step_ff <= MBE_Y_STEP_RST;
         limit_ff <= MBE_LIMIT_RST;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_X_ORIGIN: x_origin_ff <= csr_data;
            CSR_X_STEP: x_step_ff <= csr_data[MBE_STEP_WIDTH-1:0];
            CSR_Y_ORIGIN: y_origin_ff <= csr_data;
            CSR_Y_STEP: y_step_ff <= csr_data[MBE_STEP_WIDTH-1:0];
            CSR_ITER_LIMIT: limit_ff <= csr_data[MBE_COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // pixel position to point c
   assign col_prod = PROD_C_WIDTH'(col_ff) * PROD_C_WIDTH'(x_step_ff);
   assign row_prod = PROD_C_WIDTH'(row_ff) * PROD_C_WIDTH'(y_step_ff);
   assign c_re_in = MBE_C_WIDTH'(x_origin_ff) + $signed(MBE_C_WIDTH'(col_prod));
   assign c_im_in = MBE_C_WIDTH'(y_origin_ff) + $signed(MBE_C_WIDTH'(row_prod));

   // squares and cross product of z
   assign xx_in = x_ff * x_ff;
   assign yy_in = y_ff * y_ff;
   assign xy_in = x_ff * y_ff;

   // next z, floor shifts on full products
   assign nx = MBE_NXT_WIDTH'(xx_ff >>> FRAC_BITS) - MBE_NXT_WIDTH'(yy_ff >>> FRAC_BITS)
             + MBE_NXT_WIDTH'(c_re_ff);
   assign ny = MBE_NXT_WIDTH'(xy_ff >>> (FRAC_BITS - 1)) + MBE_NXT_WIDTH'(c_im_ff);
   assign nx_fits = (nx[MBE_NXT_WIDTH-1:MBE_Z_WIDTH-1] == '0)
                 || (nx[MBE_NXT_WIDTH-1:MBE_Z_WIDTH-1] == '1);
   assign ny_fits = (ny[MBE_NXT_WIDTH-1:MBE_Z_WIDTH-1] == '0)
                 || (ny[MBE_NXT_WIDTH-1:MBE_Z_WIDTH-1] == '1);

   // squared magnitude of current z from its squares
   assign mag_sum = $unsigned(xx_ff) + $unsigned(yy_ff);

   // status to the sequencer
   assign sts.len_escape = (mag_sum >> FRAC_BITS) >= FOUR;
   assign sts.limit_hit = !(count_ff < limit_ff);
   assign sts.overflow = !nx_fits || !ny_fits;

   // iteration registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff <= req_col & IDX_MASK;
         row_ff <= req_row & IDX_MASK;
      end
      if (cmd.setup) begin
         c_re_ff <= c_re_in;
         c_im_ff <= c_im_in;
         x_ff <= '0;
         y_ff <= '0;
         count_ff <= '0;
      end
      if (cmd.mul) begin
         xx_ff <= xx_in;
         yy_ff <= yy_in;
         xy_ff <= xy_in;
      end
      if (cmd.step) begin
         x_ff <= nx[MBE_Z_WIDTH-1:0];
         y_ff <= ny[MBE_Z_WIDTH-1:0];
         count_ff <= count_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_col_ff <= col_ff;
         out_row_ff <= row_ff;
         out_count_ff <= count_ff;
      end
   end

   assign rsp_out_col = out_col_ff;
   assign rsp_out_row = out_row_ff;
   assign rsp_escape_count = out_count_ff;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// testbench for the escape-time pixel engine: directed and random pixels checked by a predictor
`timescale 1ns / 100ps

module tb_top;
   import mbe_pkg::*;

   localparam int FRAC = MBE_FRAC_BITS;
   localparam longint Z_MAX = 64'sd2147483647;
   localparam longint Z_MIN = -64'sd2147483648;
   localparam int MAX_REPORTS = 10;
   localparam int CSR_SLOTS = 2 ** MBE_CSR_INDEX_WIDTH;

   // handy Q3.28 points
   localparam logic [31:0] Q_MINUS_2P25 = 32'hDC00_0000;
   localparam logic [31:0] Q_MINUS_1P5 = 32'hE800_0000;
   localparam logic [31:0] Q_MINUS_0P75 = 32'hF400_0000;
   localparam logic [31:0] Q_0P1 = 32'h0199_999A;
   localparam logic [31:0] Q_QUARTER = 32'h0400_0000;
   localparam logic [31:0] VIEW_STEP = 32'h0003_0000;

   typedef logic [MBE_COORD_WIDTH-1:0] coord_type;
   typedef logic [MBE_COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      coord_type col;
      coord_type row;
      count_type count;
   } pixel_result_type;

   logic clock;
   logic reset;

   mbe_req_if req_chan ();
   mbe_rsp_if rsp_chan ();
   mbe_csr_if csr_chan ();

   mandelbrot_escape_time dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   // register shadow, tracks every accepted write
   logic signed [MBE_ORIGIN_WIDTH-1:0] x_origin_cfg = MBE_X_ORIGIN_RST;
   logic [MBE_STEP_WIDTH-1:0] x_step_cfg = MBE_X_STEP_RST;
   logic signed [MBE_ORIGIN_WIDTH-1:0] y_origin_cfg = MBE_Y_ORIGIN_RST;
   logic [MBE_STEP_WIDTH-1:0] y_step_cfg = MBE_Y_STEP_RST;
   count_type iter_limit_cfg = MBE_LIMIT_RST;

   // engine state after the last predicted pixel
   logic [MBE_Z_WIDTH-1:0] z_re_last = '0;
   logic [MBE_Z_WIDTH-1:0] z_im_last = '0;
   count_type count_last = '0;

   pixel_result_type pending_pixels[$];
   int mismatch_count = 0;
   bit idling_on = 1'b1;
   int rsp_hold_cycles = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #8_000_000;
      $display("Verification failed");
      $finish;
   end

   // iterate z = z*z + c for one pixel with the shadowed registers
   function automatic count_type escape_iterations(input coord_type col, input coord_type row);
      longint c_re, c_im, z_re, z_im, n_re, n_im;
      longint unsigned mag;
      count_type n;
      bit escaped;
      c_re = longint'(x_origin_cfg) + longint'(col) * longint'(x_step_cfg);
      c_im = longint'(y_origin_cfg) + longint'(row) * longint'(y_step_cfg);
      z_re = 0;
      z_im = 0;
      n = '0;
      escaped = 1'b0;
      while (!escaped && n < iter_limit_cfg) begin
         n_re = ((z_re * z_re) >>> FRAC) - ((z_im * z_im) >>> FRAC) + c_re;
         n_im = ((z_re * z_im) >>> (FRAC - 1)) + c_im;
         n = n + 1'b1;
         z_re = n_re;
         z_im = n_im;
         // leaving the 32-bit range counts as escaped
         if (n_re > Z_MAX || n_re < Z_MIN || n_im > Z_MAX || n_im < Z_MIN) begin
            escaped = 1'b1;
         end else begin
            mag = $unsigned(n_re * n_re) + $unsigned(n_im * n_im);
            escaped = (mag >> FRAC) >= (64'd4 << FRAC);
         end
      end
      z_re_last = z_re[MBE_Z_WIDTH-1:0];
      z_im_last = z_im[MBE_Z_WIDTH-1:0];
      count_last = n;
      return n;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   // offer one pixel beat and record its expected result once taken
   task automatic send_pixel(input coord_type col, input coord_type row);
      int gap;
      pixel_result_type px;
      gap = (idling_on && $urandom_range(0, 2) == 0) ? idle_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.col <= col;
      req_chan.row <= row;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      px.col = col;
      px.row = row;
      px.count = escape_iterations(col, row);
      pending_pixels.push_back(px);
   endtask

   task automatic send_random(input int n);
      repeat (n) send_pixel(coord_type'($urandom_range(0, 4095)),
                            coord_type'($urandom_range(0, 4095)));
   endtask

   // drop the request and let every outstanding pixel come back
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // one register write beat; valid is left high for a following write
   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         CSR_X_ORIGIN: x_origin_cfg = value;
         CSR_X_STEP: x_step_cfg = value[MBE_STEP_WIDTH-1:0];
         CSR_Y_ORIGIN: y_origin_cfg = value;
         CSR_Y_STEP: y_step_cfg = value[MBE_STEP_WIDTH-1:0];
         CSR_ITER_LIMIT: iter_limit_cfg = value[MBE_COUNT_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic set_reg(input csr_index_type idx, input logic [31:0] value);
      wait_idle();
      write_reg(idx, value);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic load_config(input logic [31:0] x_origin, input logic [31:0] x_step,
                              input logic [31:0] y_origin, input logic [31:0] y_step,
                              input logic [31:0] limit);
      wait_idle();
      write_reg(CSR_X_ORIGIN, x_origin);
      write_reg(CSR_X_STEP, x_step);
      write_reg(CSR_Y_ORIGIN, y_origin);
      write_reg(CSR_Y_STEP, y_step);
      write_reg(CSR_ITER_LIMIT, limit);
      csr_chan.valid <= 1'b0;
   endtask

   // corners escape at once, (2048,1024) is c = 0 and runs the full default limit
   task automatic test_reset_defaults();
      send_pixel(0, 0);
      send_pixel(4095, 0);
      send_pixel(0, 4095);
      send_pixel(4095, 4095);
      send_pixel(2560, 1024);
      send_pixel(2048, 1024);
   endtask

   // zero limit, limit of one, limit above the nominal maximum
   task automatic test_iteration_limits();
      load_config(MBE_X_ORIGIN_RST, MBE_X_STEP_RST, MBE_Y_ORIGIN_RST, MBE_Y_STEP_RST, 0);
      send_pixel(2048, 1024);
      send_pixel(2560, 1024);
      set_reg(CSR_ITER_LIMIT, 1);
      send_pixel(2048, 1024);
      send_pixel(4095, 4095);
      // upper data bits are dropped by the register
      set_reg(CSR_ITER_LIMIT, 32'hFFFF_FFFF);
      send_pixel(2560, 1024);
      send_pixel(0, 0);
   endtask

   // c on the real axis: |z|^2 exactly 4, inside points, c far out of range
   task automatic test_escape_boundaries();
      load_config(MBE_X_ORIGIN_RST, Q_QUARTER, 0, 0, 32);
      send_pixel(0, coord_type'($urandom_range(0, 4095)));
      send_pixel(8, 4095);
      send_pixel(9, 0);
      send_pixel(16, coord_type'($urandom_range(0, 4095)));
      send_pixel(4095, coord_type'($urandom_range(0, 4095)));
   endtask

   // origins and steps at their extremes, then all zero
   task automatic test_register_extremes();
      load_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8);
      send_pixel(0, 0);
      send_pixel(1, 0);
      send_pixel(0, 1);
      send_pixel(4095, 4095);
      load_config(0, 0, 0, 0, 8);
      send_random(2);
   endtask

   // writes to indexes past the register list must change nothing
   task automatic test_unused_index();
      wait_idle();
      for (int k = int'(CSR_ITER_LIMIT) + 1; k < CSR_SLOTS; k++)
         write_reg(csr_index_type'(k), $urandom);
      csr_chan.valid <= 1'b0;
      send_random(2);
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_backpressure();
      load_config(Q_MINUS_2P25, VIEW_STEP, Q_MINUS_1P5, VIEW_STEP, 12);
      idling_on = 1'b0;
      rsp_hold_cycles = 400;
      send_random(6);
      idling_on = 1'b1;
   endtask

   // whole set in view, first without gaps then with them
   task automatic test_random_overview();
      load_config(Q_MINUS_2P25 + $urandom_range(0, 32'h0100_0000),
                  VIEW_STEP + $urandom_range(0, 32'h4000),
                  Q_MINUS_1P5 + $urandom_range(0, 32'h0100_0000),
                  VIEW_STEP + $urandom_range(0, 32'h4000),
                  $urandom_range(16, 96));
      idling_on = 1'b0;
      send_random(15);
      idling_on = 1'b1;
      send_random(20);
   endtask

   // small windows near the boundary, where counts spread out
   task automatic test_random_boundary();
      repeat (2) begin
         load_config(Q_MINUS_0P75 + $urandom_range(0, 32'h0100_0000),
                     $urandom_range(256, 4096),
                     Q_0P1 + $urandom_range(0, 32'h0100_0000),
                     $urandom_range(256, 4096),
                     $urandom_range(64, 255));
         send_random(15);
      end
   endtask

   // arbitrary registers, mostly out-of-range points
   task automatic test_random_wild();
      repeat (3) begin
         load_config($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 40));
         send_random(10);
      end
   endtask

   task automatic finish_run();
      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   endtask

   // test sequence
   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.col <= '0;
      req_chan.row <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= CSR_X_ORIGIN;
      csr_chan.data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_iteration_limits();
      test_escape_boundaries();
      test_register_extremes();
      test_unused_index();
      test_backpressure();
      test_random_overview();
      test_random_boundary();
      test_random_wild();
      finish_run();
   end

   // result receiver: random stalls plus an occasional long hold
   initial begin
      int hold;
      rsp_chan.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            hold = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (idle_gap()) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // compare each result beat with the oldest expected pixel
   always @(posedge clock) begin : result_check
      pixel_result_type want;
      if (reset === 1'b0 && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result beat: col %0d row %0d count %0d",
                        rsp_chan.out_col, rsp_chan.out_row, rsp_chan.escape_count);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_chan.out_col !== want.col || rsp_chan.out_row !== want.row ||
                rsp_chan.escape_count !== want.count) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected col %0d row %0d count %0d, got col %0d row %0d count %0d",
                           want.col, want.row, want.count, rsp_chan.out_col,
                           rsp_chan.out_row, rsp_chan.escape_count);
            end
         end
      end
   end

endmodule

@@ sim.f @@
hdl/mbe_pkg.sv
hdl/mbe_if.sv
hdl/mbe_ctrl.sv
hdl/mbe_dpath.sv
hdl/mandelbrot_escape_time.sv
test/tb_top.sv
